[src/first_fit_arena_allocator_unit_defines.svh]
// assertion macros for the first fit arena allocator
// each macro samples on clk and is disabled while arst_n is low
`ifndef FIRST_FIT_ARENA_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_ARENA_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every edge
`define FFA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define FFA_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define FFA_ASSERT(label, prop, msg)
`define FFA_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

[src/ffa_pkg.sv]
package ffa_pkg;

	// field widths
	localparam int OP_W     = 2;
	localparam int ADDR_W   = 10;
	localparam int STATUS_W = 2;

	// default geometry
	localparam int ARENA_BYTES_DEF   = 1024;
	localparam int GRANULE_BYTES_DEF = 16;
	localparam int HEADER_BYTES_DEF  = 16;

	// operation codes
	localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
	localparam logic [OP_W-1:0] OP_REINIT = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

	// request word
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] req_bytes;
		logic [ADDR_W-1:0] free_addr;
	} req_t;

	// response word
	typedef struct packed {
		logic [ADDR_W-1:0]   result_addr;
		logic [STATUS_W-1:0] status;
	} rsp_t;

endpackage

[src/ffa_ram.sv]
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/first_fit_arena_allocator_unit.sv]
// channel   direction   handshake                 word
// req       in          req_valid / req_ready     ffa_pkg::req_t  (op, req_bytes, free_addr)
// rsp       out         rsp_valid / rsp_ready     ffa_pkg::rsp_t  (result_addr, status)
//
// allocate and free walk the block headers in the header memory, one header a cycle, since
// each read address is the previous start plus the length just read; the steps are taking
// the word, the header walk, a write of the split header when allocate splits a block, and
// loading the response
// reinitialise and the unused op go from taking the word to loading the response; reinitialise clears the valid bits
// reset empties the valid bits, so no clearing pass is needed; one word is worked at a time
// a new word is taken while a response waits; the response stage stalls on rsp_ready
`include "first_fit_arena_allocator_unit_defines.svh"

module first_fit_arena_allocator_unit #(
	parameter int ARENA_BYTES   = ffa_pkg::ARENA_BYTES_DEF,
	parameter int GRANULE_BYTES = ffa_pkg::GRANULE_BYTES_DEF,
	parameter int HEADER_BYTES  = ffa_pkg::HEADER_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ffa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ffa_pkg::rsp_t rsp
);

	// geometry; the user must keep the granule a power of two, which the block itself does not enforce
	localparam int AddrW     = ffa_pkg::ADDR_W;
	localparam int GranCount = ARENA_BYTES / GRANULE_BYTES;
	localparam int HdrGrans  = (HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
	localparam int GranShift = $clog2(GRANULE_BYTES);
	localparam int IdxW      = $clog2(GranCount);
	localparam int LenW      = $clog2(GranCount + 1);
	localparam int EntW      = LenW + 1;
	localparam int SumW      = LenW + 1;
	localparam int NeedW     = AddrW + 1;
	localparam int CmpW      = (NeedW > LenW) ? NeedW : LenW;
	localparam int OffW      = $clog2(GranCount + HdrGrans + 1) + GranShift;
	localparam int CmpOffW   = (OffW > AddrW) ? OffW : AddrW;

	localparam logic [LenW-1:0]  HdrLen    = LenW'(HdrGrans);
	localparam logic [LenW-1:0]  MinSplit  = LenW'(HdrGrans + 1);
	localparam logic [SumW-1:0]  EndIdx    = SumW'(GranCount);
	localparam logic [EntW-1:0]  FirstEnt  = EntW'(GranCount);
	localparam logic [AddrW-1:0] GranMask  = AddrW'(GRANULE_BYTES - 1);
	localparam logic [NeedW-1:0] RoundUp   = NeedW'(GRANULE_BYTES - 1);

	// sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_WALK  = 2'd1;
	localparam logic [1:0] S_SPLIT = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0]                     state_q;
	logic [ffa_pkg::OP_W-1:0]       op_q;
	logic [NeedW-1:0]               need_q;
	logic [AddrW-1:0]               faddr_q;
	logic [IdxW-1:0]                i_q;
	logic [IdxW-1:0]                split_idx_q;
	logic [LenW-1:0]                spare_q;
	logic [AddrW-1:0]               res_addr_q;
	logic [ffa_pkg::STATUS_W-1:0]   res_status_q;
	logic [GranCount-1:0]           valid_q;
	logic                           entry_valid_s1;
	logic                           rsp_valid_q;
	ffa_pkg::rsp_t                  rsp_q;

	logic                           ram_we;
	logic [IdxW-1:0]                ram_waddr;
	logic [EntW-1:0]                ram_wdata;
	logic [IdxW-1:0]                ram_raddr;
	logic [EntW-1:0]                ram_rdata;

	logic [EntW-1:0]                ent;
	logic                           ent_used;
	logic [LenW-1:0]                ent_len_raw;
	logic [LenW-1:0]                len;
	logic [LenW-1:0]                payload;
	logic [LenW-1:0]                need_len;
	logic [LenW-1:0]                spare;
	logic [LenW-1:0]                new_len;
	logic                           fit;
	logic                           do_split;
	logic [SumW-1:0]                next_i;
	logic [SumW-1:0]                nxt_blk;
	logic [OffW-1:0]                pos_off;
	logic                           addr_hit;
	logic                           walk_end;
	logic                           rsp_free;

	// header memory
	ffa_ram #(
		.WIDTH(EntW),
		.DEPTH(GranCount)
	) u_hdr_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// valid bit of the entry being read, aligned with the read data
	always_ff @(posedge clk) begin
		entry_valid_s1 <= valid_q[ram_raddr];
	end

	// header decode; a never written entry reads as the reset header at index 0 and as zero elsewhere
	assign ent         = entry_valid_s1 ? ram_rdata : ((i_q == '0) ? FirstEnt : '0);
	assign ent_used    = ent[EntW-1];
	assign ent_len_raw = ent[LenW-1:0];
	assign len         = (ent_len_raw == '0) ? LenW'(1) : ent_len_raw;
	assign payload     = len - HdrLen;
	assign need_len    = LenW'(need_q);
	assign fit         = !ent_used && (len >= HdrLen) && (CmpW'(need_q) <= CmpW'(payload));
	assign spare       = payload - need_len;
	assign do_split    = spare >= MinSplit;
	assign new_len     = do_split ? (HdrLen + need_len) : len;
	assign next_i      = SumW'(i_q) + SumW'(len);
	assign nxt_blk     = SumW'(i_q) + SumW'(HdrLen) + SumW'(need_len);
	assign walk_end    = next_i >= EndIdx;
	assign pos_off     = (OffW'(i_q) + OffW'(HdrGrans)) << GranShift;
	assign addr_hit    = CmpOffW'(pos_off) == CmpOffW'(faddr_q);
	assign rsp_free    = !rsp_valid_q || rsp_ready;

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = i_q;
		ram_wdata = '0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = '0;
			end
			S_WALK: begin
				ram_raddr = next_i[IdxW-1:0];
				if (op_q == ffa_pkg::OP_ALLOC && fit) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b1, new_len};
				end else if (op_q == ffa_pkg::OP_FREE && addr_hit && ent_used) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b0, ent_len_raw};
				end
			end
			S_SPLIT: begin
				ram_we    = 1'b1;
				ram_waddr = split_idx_q;
				ram_wdata = {1'b0, spare_q};
			end
			S_FIN: begin
				ram_raddr = '0;
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			rsp_valid_q  <= 1'b0;
			op_q         <= ffa_pkg::OP_ALLOC;
			need_q       <= '0;
			faddr_q      <= '0;
			i_q          <= '0;
			split_idx_q  <= '0;
			spare_q      <= '0;
			res_addr_q   <= '0;
			res_status_q <= ffa_pkg::ST_OK;
			rsp_q        <= '0;
		end else begin
			// a word taken here is replaced below when the next one is loaded
			if (rsp_valid_q && rsp_ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q         <= req.op;
						need_q       <= (NeedW'(req.req_bytes) + RoundUp) >> GranShift;
						faddr_q      <= req.free_addr;
						i_q          <= '0;
						res_addr_q   <= '0;
						res_status_q <= ffa_pkg::ST_OK;
						case (req.op) inside
							ffa_pkg::OP_ALLOC, ffa_pkg::OP_FREE: begin
								state_q <= S_WALK;
							end
							ffa_pkg::OP_REINIT: begin
								valid_q <= '0;
								state_q <= S_FIN;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_WALK: begin
					if (op_q == ffa_pkg::OP_ALLOC) begin
						if (fit) begin
							res_addr_q   <= AddrW'(pos_off);
							res_status_q <= ffa_pkg::ST_OK;
							if (do_split && nxt_blk < EndIdx) begin
								split_idx_q <= nxt_blk[IdxW-1:0];
								spare_q     <= spare;
								state_q     <= S_SPLIT;
							end else begin
								state_q <= S_FIN;
							end
						end else if (walk_end) begin
							res_status_q <= ffa_pkg::ST_NOSPACE;
							state_q      <= S_FIN;
						end else begin
							i_q <= next_i[IdxW-1:0];
						end
					end else begin
						if (addr_hit) begin
							res_status_q <= ent_used ? ffa_pkg::ST_OK : ffa_pkg::ST_BADFREE;
							state_q      <= S_FIN;
						end else if (walk_end) begin
							res_status_q <= ffa_pkg::ST_BADFREE;
							state_q      <= S_FIN;
						end else begin
							i_q <= next_i[IdxW-1:0];
						end
					end
				end
				S_SPLIT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (rsp_free) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.result_addr <= res_addr_q;
						rsp_q.status      <= res_status_q;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`FFA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, state_q != S_IDLE, "accepted word left the sequencer idle")
	`FFA_ASSERT(a_fail_addr_zero, !rsp_valid || rsp.status == ffa_pkg::ST_OK || rsp.result_addr == '0, "failed response carries an address")
	`FFA_ASSERT(a_ok_addr_aligned, !rsp_valid || (rsp.result_addr & GranMask) == '0, "response address off granule")
	`FFA_ASSERT_NEXT(a_split_after_fit, state_q == S_WALK && !ram_we, state_q != S_SPLIT, "split without a used header write")

endmodule
